// ----- src/linear_probe_binding_table_defines.svh -----
// assertion macros used by the binding table rtl
`ifndef LINEAR_PROBE_BINDING_TABLE_DEFINES_SVH
`define LINEAR_PROBE_BINDING_TABLE_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define LPBT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define LPBT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lpbt_pkg.sv -----
// types, constants and helpers of the linear probe binding table
`default_nettype none

package lpbt_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int LIVE_W      = 7;

    typedef enum logic [1:0] {
        CMD_GET    = 2'd0,
        CMD_SET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_REHASH = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_INSERTED = 3'd1,
        ST_MISS     = 3'd2,
        ST_FULL     = 3'd3,
        ST_REHASHED = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] new_value;
    } in_beat_t;

    typedef struct packed {
        status_t           status;
        logic [VAL_W-1:0]  read_value;
        logic [LIVE_W-1:0] live_count;
    } out_beat_t;

    typedef struct packed {
        logic             tomb;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } copy_word_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        slot_word_t       wr_word;
        logic             clear_all;
        logic             cp_wr_en;
        logic [IDX_W-1:0] cp_wr_addr;
        copy_word_t       cp_wr_word;
        logic             cp_rd_en;
        logic [IDX_W-1:0] cp_rd_addr;
    } store_req_t;

    typedef struct packed {
        logic       occ;
        slot_word_t word;
        copy_word_t cp_word;
    } store_rsp_t;

    // home slot: (key >> 2) mod TABLE_SLOTS, a mask for a power-of-two table
    function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] sh;
        sh = key >> 2;
        return sh[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/linear_probe_binding_table.sv -----
// Open-addressed key/value table with linear probing and tombstones.
// One command beat in on s_ (valid/ready): get, set, remove or rehash.
// One result beat out on m_ (valid/ready): status, value read, live count.
// Commands run one at a time. A get, set or remove goes from acceptance
// to the result register through k probes, k being the slots probed
// (1 to 64): each probe is a read of the slot memory and an evaluate
// step, write-back included. A new beat is taken only after the done
// state has loaded the output register and the block is back in idle.
// Rehash sweeps all 64 slots and copies each live entry into the copy
// memory, clears the occupancy flags and the live count in the evaluate
// step of the last slot, then reinserts each copied entry through the
// set probe. Reset clears all occupancy flags, so the table is empty
// once reset ends; no clearing pass is needed.
// The result sits in an output register; while the receiver stalls the
// block may finish the next command and then holds it until m_ready.
`default_nettype none

`include "linear_probe_binding_table_defines.svh"

module linear_probe_binding_table (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lpbt_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lpbt_pkg::out_beat_t      m_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRB_RD,
        S_PRB_EV,
        S_RH_RD,
        S_RH_EV,
        S_RH_LD,
        S_RH_LDW,
        S_DONE
    } state_t;

    localparam logic [lpbt_pkg::IDX_W-1:0] LAST_IDX =
        lpbt_pkg::IDX_W'(lpbt_pkg::TABLE_SLOTS - 1);

    state_t                       state_reg;
    lpbt_pkg::cmd_t               cmd_reg;
    logic [lpbt_pkg::KEY_W-1:0]   key_reg;
    logic [lpbt_pkg::VAL_W-1:0]   val_reg;
    logic [lpbt_pkg::IDX_W-1:0]   slot_reg;
    logic [lpbt_pkg::IDX_W-1:0]   cnt_reg;
    logic                         have_tomb_reg;
    logic [lpbt_pkg::IDX_W-1:0]   tomb_slot_reg;
    logic [lpbt_pkg::CNT_W-1:0]   total_reg;
    logic                         rh_mode_reg;
    logic [lpbt_pkg::IDX_W-1:0]   rh_idx_reg;
    logic [lpbt_pkg::CNT_W-1:0]   rh_n_reg;
    logic [lpbt_pkg::CNT_W-1:0]   rh_j_reg;
    lpbt_pkg::status_t            res_status_reg;
    logic [lpbt_pkg::VAL_W-1:0]   res_value_reg;
    logic                         m_valid_reg;
    lpbt_pkg::out_beat_t          m_data_reg;

    lpbt_pkg::store_req_t         store_req;
    lpbt_pkg::store_rsp_t         store_rsp;

    logic                         live;
    logic                         is_tomb;
    logic                         match;
    logic                         last;
    logic                         eff_have;
    logic [lpbt_pkg::IDX_W-1:0]   eff_tomb;
    logic [lpbt_pkg::IDX_W-1:0]   next_slot;
    logic                         ev_done;
    lpbt_pkg::status_t            ev_status;
    logic [lpbt_pkg::VAL_W-1:0]   ev_value;
    logic                         ev_inc;
    logic                         ev_dec;
    logic                         ev_wr;
    logic [lpbt_pkg::IDX_W-1:0]   ev_wr_addr;
    lpbt_pkg::slot_word_t         ev_wr_word;

    lpbt_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (store_req),
        .rsp     (store_rsp)
    );

    // evaluate the probed slot
    always_comb begin
        live      = store_rsp.occ & ~store_rsp.word.tomb;
        is_tomb   = store_rsp.occ & store_rsp.word.tomb;
        match     = live && (store_rsp.word.key == key_reg);
        last      = (cnt_reg == LAST_IDX);
        eff_have  = have_tomb_reg | is_tomb;
        eff_tomb  = have_tomb_reg ? tomb_slot_reg : slot_reg;
        next_slot = (slot_reg == LAST_IDX) ? '0 : slot_reg + 1'b1;

        ev_done    = 1'b0;
        ev_status  = lpbt_pkg::ST_MISS;
        ev_value   = '0;
        ev_inc     = 1'b0;
        ev_dec     = 1'b0;
        ev_wr      = 1'b0;
        ev_wr_addr = slot_reg;
        ev_wr_word = '{tomb: 1'b0, key: key_reg, value: val_reg};

        case (cmd_reg)
            lpbt_pkg::CMD_GET: begin
                if (!store_rsp.occ || last) begin
                    ev_done = 1'b1;
                end
                if (match) begin
                    ev_done   = 1'b1;
                    ev_status = lpbt_pkg::ST_HIT;
                    ev_value  = store_rsp.word.value;
                end
            end
            lpbt_pkg::CMD_REMOVE: begin
                if (!store_rsp.occ || last) begin
                    ev_done = 1'b1;
                end
                if (match) begin
                    ev_done    = 1'b1;
                    ev_status  = lpbt_pkg::ST_HIT;
                    ev_dec     = (total_reg != '0);
                    ev_wr      = 1'b1;
                    ev_wr_word = '{tomb: 1'b1, key: key_reg, value: '0};
                end
            end
            lpbt_pkg::CMD_SET: begin
                if (match) begin
                    ev_done   = 1'b1;
                    ev_status = lpbt_pkg::ST_HIT;
                    ev_wr     = 1'b1;
                end else if (!store_rsp.occ) begin
                    // empty slot ends the chain: reuse the first tombstone passed, else this slot
                    ev_done    = 1'b1;
                    ev_status  = lpbt_pkg::ST_INSERTED;
                    ev_inc     = 1'b1;
                    ev_wr      = 1'b1;
                    ev_wr_addr = eff_tomb;
                end else if (last) begin
                    ev_done = 1'b1;
                    if (eff_have) begin
                        ev_status  = lpbt_pkg::ST_INSERTED;
                        ev_inc     = 1'b1;
                        ev_wr      = 1'b1;
                        ev_wr_addr = eff_tomb;
                    end else begin
                        ev_status = lpbt_pkg::ST_FULL;
                    end
                end
            end
            default: begin
                ev_done = 1'b1;
            end
        endcase
    end

    // memory requests per state
    always_comb begin
        store_req            = '0;
        store_req.rd_addr    = slot_reg;
        store_req.wr_addr    = ev_wr_addr;
        store_req.wr_word    = ev_wr_word;
        store_req.cp_wr_addr = rh_n_reg[lpbt_pkg::IDX_W-1:0];
        store_req.cp_wr_word = '{key: store_rsp.word.key, value: store_rsp.word.value};
        store_req.cp_rd_addr = rh_j_reg[lpbt_pkg::IDX_W-1:0];
        case (state_reg)
            S_PRB_RD: begin
                store_req.rd_en = 1'b1;
            end
            S_PRB_EV: begin
                store_req.wr_en = ev_wr;
            end
            S_RH_RD: begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = rh_idx_reg;
            end
            S_RH_EV: begin
                store_req.cp_wr_en  = live;
                store_req.clear_all = (rh_idx_reg == LAST_IDX);
            end
            S_RH_LD: begin
                store_req.cp_rd_en = (rh_j_reg != rh_n_reg);
            end
            default: begin
                store_req.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
        end else begin
            // the done state reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg       <= s_data.cmd;
                        key_reg       <= s_data.key;
                        val_reg       <= s_data.new_value;
                        slot_reg      <= lpbt_pkg::home_slot(s_data.key);
                        cnt_reg       <= '0;
                        have_tomb_reg <= 1'b0;
                        rh_idx_reg    <= '0;
                        rh_n_reg      <= '0;
                        if (s_data.cmd == lpbt_pkg::CMD_REHASH) begin
                            rh_mode_reg <= 1'b1;
                            state_reg   <= S_RH_RD;
                        end else begin
                            rh_mode_reg <= 1'b0;
                            state_reg   <= S_PRB_RD;
                        end
                    end
                end
                S_PRB_RD: begin
                    state_reg <= S_PRB_EV;
                end
                S_PRB_EV: begin
                    if (ev_inc) begin
                        total_reg <= total_reg + 1'b1;
                    end else if (ev_dec) begin
                        total_reg <= total_reg - 1'b1;
                    end
                    if (ev_done) begin
                        if (rh_mode_reg) begin
                            rh_j_reg  <= rh_j_reg + 1'b1;
                            state_reg <= S_RH_LD;
                        end else begin
                            res_status_reg <= ev_status;
                            res_value_reg  <= ev_value;
                            state_reg      <= S_DONE;
                        end
                    end else begin
                        if (is_tomb && !have_tomb_reg) begin
                            have_tomb_reg <= 1'b1;
                            tomb_slot_reg <= slot_reg;
                        end
                        slot_reg  <= next_slot;
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_PRB_RD;
                    end
                end
                S_RH_RD: begin
                    state_reg <= S_RH_EV;
                end
                S_RH_EV: begin
                    if (live) begin
                        rh_n_reg <= rh_n_reg + 1'b1;
                    end
                    if (rh_idx_reg == LAST_IDX) begin
                        total_reg <= '0;
                        rh_j_reg  <= '0;
                        state_reg <= S_RH_LD;
                    end else begin
                        rh_idx_reg <= rh_idx_reg + 1'b1;
                        state_reg  <= S_RH_RD;
                    end
                end
                S_RH_LD: begin
                    if (rh_j_reg == rh_n_reg) begin
                        res_status_reg <= lpbt_pkg::ST_REHASHED;
                        res_value_reg  <= '0;
                        state_reg      <= S_DONE;
                    end else begin
                        state_reg <= S_RH_LDW;
                    end
                end
                S_RH_LDW: begin
                    // copied entry reinserted through the set probe
                    key_reg       <= store_rsp.cp_word.key;
                    val_reg       <= store_rsp.cp_word.value;
                    cmd_reg       <= lpbt_pkg::CMD_SET;
                    slot_reg      <= lpbt_pkg::home_slot(store_rsp.cp_word.key);
                    cnt_reg       <= '0;
                    have_tomb_reg <= 1'b0;
                    state_reg     <= S_PRB_RD;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.status     <= res_status_reg;
                        m_data_reg.read_value <= res_value_reg;
                        m_data_reg.live_count <= lpbt_pkg::LIVE_W'(total_reg);
                        m_valid_reg           <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `LPBT_ASSERT_IMP(a_total_bound, 1'b1, total_reg <= lpbt_pkg::CNT_W'(lpbt_pkg::TABLE_SLOTS), "live count above table size")
    `LPBT_ASSERT_IMP(a_get_no_write, state_reg == S_PRB_EV && cmd_reg == lpbt_pkg::CMD_GET, !store_req.wr_en, "get wrote the slot memory")
    `LPBT_ASSERT_IMP(a_write_in_probe, store_req.wr_en, state_reg == S_PRB_EV, "slot write outside probe evaluate")
    `LPBT_ASSERT_IMP(a_rehash_count, state_reg == S_RH_LD && rh_j_reg == rh_n_reg, total_reg == rh_n_reg, "rehash lost or added entries")
    `LPBT_ASSERT_NXT(a_accept_starts, s_valid && s_ready, state_reg == S_PRB_RD || state_reg == S_RH_RD, "accepted beat did not start work")

endmodule

`default_nettype wire

// ----- src/lpbt_store.sv -----
// slot memory with occupancy flags, and the rehash copy memory
`default_nettype none

module lpbt_store (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lpbt_pkg::store_req_t req,
    output lpbt_pkg::store_rsp_t      rsp
);

    lpbt_pkg::slot_word_t slot_mem [lpbt_pkg::TABLE_SLOTS];
    lpbt_pkg::copy_word_t copy_mem [lpbt_pkg::TABLE_SLOTS];

    logic [lpbt_pkg::TABLE_SLOTS-1:0] occ_reg;
    logic [lpbt_pkg::IDX_W-1:0]       rd_addr_reg;
    lpbt_pkg::slot_word_t             rd_word_reg;
    lpbt_pkg::copy_word_t             cp_word_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            slot_mem[req.wr_addr] <= req.wr_word;
        end
        if (req.rd_en) begin
            rd_word_reg <= slot_mem[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.cp_wr_en) begin
            copy_mem[req.cp_wr_addr] <= req.cp_wr_word;
        end
        if (req.cp_rd_en) begin
            cp_word_reg <= copy_mem[req.cp_rd_addr];
        end
    end

    // a slot that is not occupied reads as empty, whatever the memory holds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (req.clear_all) begin
            occ_reg <= '0;
        end else if (req.wr_en) begin
            occ_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rsp.occ     = occ_reg[rd_addr_reg];
    assign rsp.word    = rd_word_reg;
    assign rsp.cp_word = cp_word_reg;

endmodule

`default_nettype wire
